FILE: src/vlmf_pkg.sv
package vlmf_pkg;

    // Store geometry. Both sizes are powers of two so ring positions wrap by truncation.
    localparam int BUF_BYTES = 256;
    localparam int RECORDS   = 16;
    localparam int BYTE_AW   = $clog2(BUF_BYTES);
    localparam int REC_AW    = $clog2(RECORDS);
    localparam int REC_PW    = REC_AW + 1;
    localparam int LEN_W     = 9;

    // Commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;

    // Result status codes.
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_NO_ROOM  = 3'd1;
    localparam logic [2:0] STATUS_EMPTY    = 3'd2;
    localparam logic [2:0] STATUS_TOO_LONG = 3'd3;
    localparam logic [2:0] STATUS_QUERY    = 3'd4;

    typedef struct packed {
        logic [1:0]       command;
        logic [7:0]       data_in;
        logic [LEN_W-1:0] message_length;
        logic             overwrite;
        logic [LEN_W-1:0] max_length;
    } req_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        data_out;
        logic              last_byte;
        logic [LEN_W-1:0]  free_bytes;
        logic [REC_PW-1:0] messages_waiting;
        logic [REC_PW-1:0] dropped;
    } rsp_item_t;

endpackage

FILE: src/vlmf_req_if.sv
interface vlmf_req_if
    import vlmf_pkg::*;
();
    logic      valid;
    logic      ready;
    req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: src/vlmf_rsp_if.sv
interface vlmf_rsp_if
    import vlmf_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: src/variable_length_message_fifo.sv
// Variable-length message FIFO: whole messages of 1 to 256 bytes are written one byte
// per request beat, the first beat carrying the total length and deciding admission,
// and read back one byte per request beat from the oldest committed message. Bytes
// live in a 256-entry synchronous RAM and lengths in a 16-entry synchronous RAM,
// each with a registered read port. Each request has an accept step, which presents
// the RAM read addresses, and an evaluation step that updates the pointers
// and loads the response register. A write beat that opens a message
// with overwrite set takes one extra cycle per oldest message dropped, since each
// drop must read the next length record. The evaluation step also waits while the
// response register still holds an untaken beat. Both RAMs start with undefined
// contents; no clearing pass is run after reset.
module variable_length_message_fifo
    import vlmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vlmf_req_if.sink   request,
    vlmf_rsp_if.source response
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic              state_reg, state_next;
    req_item_t         item_reg;
    logic [BYTE_AW-1:0] bwp_reg, bwp_next;
    logic [BYTE_AW-1:0] brp_reg, brp_next;
    logic [LEN_W-1:0]  held_reg, held_next;
    logic [REC_PW-1:0] rwp_reg, rwp_next;
    logic [REC_PW-1:0] rrp_reg, rrp_next;
    logic [LEN_W-1:0]  write_left_reg, write_left_next;
    logic              refused_reg, refused_next;
    logic [LEN_W-1:0]  pending_reg, pending_next;
    logic [LEN_W-1:0]  read_left_reg, read_left_next;
    logic [REC_PW-1:0] dropped_reg, dropped_next;
    logic              out_valid_reg, out_valid_next;
    rsp_item_t         out_item_reg, out_item_next;

    // Storage.
    logic [7:0]       byte_mem [BUF_BYTES];
    logic [LEN_W-1:0] rec_mem [RECORDS];
    logic [7:0]       byte_rd_reg;
    logic [LEN_W-1:0] rec_rd_reg;
    logic             byte_we;
    logic             rec_we;
    logic [LEN_W-1:0] rec_wdata;

    // Derived status of the current state.
    logic [REC_PW-1:0] count;
    logic [LEN_W-1:0]  free_now;
    logic              first_byte;
    logic              fits_store;
    logic              need_room;
    logic              drop_now;
    logic              finish;
    logic              accept;

    assign accept        = request.valid && request.ready;
    assign request.ready = (state_reg == ST_IDLE);
    assign response.valid = out_valid_reg;
    assign response.item  = out_item_reg;

    assign count      = rwp_reg - rrp_reg;
    assign free_now   = LEN_W'(BUF_BYTES) - held_reg;
    assign first_byte = (write_left_reg == '0) && (item_reg.message_length != '0);
    assign fits_store = (item_reg.message_length <= LEN_W'(BUF_BYTES));
    assign need_room  = (free_now < item_reg.message_length)
                        || (count >= REC_PW'(RECORDS));
    assign drop_now   = (state_reg == ST_EVAL) && (item_reg.command == CMD_WRITE)
                        && first_byte && fits_store && item_reg.overwrite
                        && need_room && (count != '0);
    assign finish     = (state_reg == ST_EVAL) && !drop_now
                        && (!out_valid_reg || response.ready);

    // Sequencer: drop step, or final evaluation of the held request.
    always_comb
    begin
        logic [LEN_W-1:0]  n_drop;
        logic [LEN_W-1:0]  wl;
        logic [LEN_W-1:0]  rl;
        logic [LEN_W-1:0]  held;
        logic [LEN_W-1:0]  pend;
        logic              refd;
        logic              admit;
        logic [2:0]        status;
        logic [7:0]        dout;
        logic              last;

        state_next      = state_reg;
        bwp_next        = bwp_reg;
        brp_next        = brp_reg;
        held_next       = held_reg;
        rwp_next        = rwp_reg;
        rrp_next        = rrp_reg;
        write_left_next = write_left_reg;
        refused_next    = refused_reg;
        pending_next    = pending_reg;
        read_left_next  = read_left_reg;
        dropped_next    = dropped_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        byte_we         = 1'b0;
        rec_we          = 1'b0;
        rec_wdata       = pending_reg;

        n_drop = (read_left_reg != '0) ? read_left_reg : rec_rd_reg;
        if (n_drop > held_reg)
        begin
            n_drop = held_reg;
        end
        wl     = write_left_reg;
        rl     = read_left_reg;
        held   = held_reg;
        pend   = pending_reg;
        refd   = refused_reg;
        admit  = 1'b0;
        status = STATUS_QUERY;
        dout   = '0;
        last   = 1'b0;

        if (response.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            state_next   = ST_EVAL;
            dropped_next = '0;
        end

        if (drop_now)
        begin
            // Discard the oldest message whole, including any partly read remainder.
            brp_next       = brp_reg + n_drop[BYTE_AW-1:0];
            held_next      = held_reg - n_drop;
            read_left_next = '0;
            rrp_next       = rrp_reg + 1'b1;
            dropped_next   = dropped_reg + 1'b1;
        end
        else if (finish)
        begin
            case (item_reg.command)
                CMD_WRITE:
                begin
                    status = STATUS_NO_ROOM;
                    // The first byte reserves the whole message or marks it refused.
                    if (first_byte)
                    begin
                        admit = fits_store && (free_now >= item_reg.message_length)
                                && (count < REC_PW'(RECORDS));
                        wl    = item_reg.message_length;
                        refd  = !admit;
                        if (admit)
                        begin
                            pend = item_reg.message_length;
                            held = held + item_reg.message_length;
                        end
                    end
                    if (wl != '0)
                    begin
                        if (!refd)
                        begin
                            byte_we  = 1'b1;
                            bwp_next = bwp_reg + 1'b1;
                            status   = STATUS_OK;
                        end
                        wl = wl - 1'b1;
                        // The last byte commits the length record.
                        if (wl == '0)
                        begin
                            if (!refd)
                            begin
                                rec_we   = 1'b1;
                                rwp_next = rwp_reg + 1'b1;
                            end
                            refd = 1'b0;
                        end
                    end
                end
                CMD_READ:
                begin
                    status = STATUS_EMPTY;
                    // Before the first byte, check the length against the receiver.
                    if ((rl == '0) && (count != '0))
                    begin
                        if (rec_rd_reg > item_reg.max_length)
                        begin
                            status = STATUS_TOO_LONG;
                        end
                        else
                        begin
                            rl = rec_rd_reg;
                        end
                    end
                    if ((rl != '0) && (held != '0))
                    begin
                        dout     = byte_rd_reg;
                        brp_next = brp_reg + 1'b1;
                        held     = held - 1'b1;
                        rl       = rl - 1'b1;
                        status   = STATUS_OK;
                        if (rl == '0)
                        begin
                            last     = 1'b1;
                            rrp_next = rrp_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    status = STATUS_QUERY;
                end
            endcase

            write_left_next = wl;
            refused_next    = refd;
            pending_next    = pend;
            read_left_next  = rl;
            held_next       = held;
            rec_wdata       = pend;
            state_next      = ST_IDLE;
            out_valid_next  = 1'b1;

            out_item_next.status           = status;
            out_item_next.data_out         = dout;
            out_item_next.last_byte        = last;
            out_item_next.free_bytes       = LEN_W'(BUF_BYTES) - held;
            out_item_next.messages_waiting = rwp_next - rrp_next;
            out_item_next.dropped          = dropped_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bwp_reg        <= '0;
            brp_reg        <= '0;
            held_reg       <= '0;
            rwp_reg        <= '0;
            rrp_reg        <= '0;
            write_left_reg <= '0;
            refused_reg    <= 1'b0;
            pending_reg    <= '0;
            read_left_reg  <= '0;
            dropped_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bwp_reg        <= bwp_next;
            brp_reg        <= brp_next;
            held_reg       <= held_next;
            rwp_reg        <= rwp_next;
            rrp_reg        <= rrp_next;
            write_left_reg <= write_left_next;
            refused_reg    <= refused_next;
            pending_reg    <= pending_next;
            read_left_reg  <= read_left_next;
            dropped_reg    <= dropped_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= request.item;
        end
        out_item_reg <= out_item_next;
    end

    // Byte RAM: read follows the next read pointer, so its data matches the pointer
    // once that pointer is registered.
    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[bwp_reg] <= item_reg.data_in;
        end
        byte_rd_reg <= byte_mem[brp_next];
    end

    // Length record RAM: read follows the next record read position.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rwp_reg[REC_AW-1:0]] <= rec_wdata;
        end
        rec_rd_reg <= rec_mem[rrp_next[REC_AW-1:0]];
    end

endmodule
